>>> rtl/shd_pkg.sv
// Package for the soft-decision Hamming ML decoder: widths, control structs,
// and the candidate codeword tables. No dependencies.
package shd_pkg;

  localparam int SOFT_WIDTH_DEF = 16;
  localparam int CODE_RATE_W    = 3;
  localparam int NIB_DEPTH      = 4;   // nibble queue depth, power of two
  localparam int NIB_PTR_W      = $clog2(NIB_DEPTH);
  localparam int NIB_CNT_W      = $clog2(NIB_DEPTH + 1);
  localparam int NUM_CELLS      = 4;   // four cells in the argmin chain, four candidates per cell

  localparam logic [CODE_RATE_W-1:0] RATE_RST = 3'd4;
  localparam logic [CODE_RATE_W-1:0] RATE_MIN = 3'd1;
  localparam logic [CODE_RATE_W-1:0] RATE_MAX = 3'd4;
  localparam logic [1:0]             LAST_BIT_IDX = 2'd3;

  // controls broadcast to every cell
  typedef struct packed {
    logic fire;      // input beat accepted
    logic first;     // beat is position zero of a codeword
    logic grp_end;   // previous cycle closed a codeword
  } acc_ctl_t;

  // argmin token passed along the chain (score travels beside it)
  typedef struct packed {
    logic       vld;
    logic [3:0] idx;
  } tok_t;

  // out-of-range rates fold onto the nearest legal one
  function automatic logic [CODE_RATE_W-1:0] eff_rate(input logic [CODE_RATE_W-1:0] r);
    logic [CODE_RATE_W-1:0] e;
    if (r == '0) e = RATE_MIN;
    else if (r > RATE_MAX) e = RATE_MAX;
    else e = r;
    return e;
  endfunction

  // bit at position pos of the codeword carrying nibble n (n[3] is d0)
  function automatic logic code_bit(input logic [CODE_RATE_W-1:0] r,
                                    input logic [3:0] n,
                                    input logic [2:0] pos);
    logic d0, d1, d2, d3;
    logic [2:0] k;
    logic b;
    d0 = n[3];
    d1 = n[2];
    d2 = n[1];
    d3 = n[0];
    k  = pos - r;
    b  = 1'b0;
    if (pos >= r) begin
      if (k <= 3'd3) b = n[2'd3 - k[1:0]];
    end else begin
      unique case (r)
        3'd4: begin
          unique case (pos)
            3'd0:    b = d0 ^ d1 ^ d3;
            3'd1:    b = d0 ^ d2 ^ d3;
            3'd2:    b = d0 ^ d1 ^ d2;
            default: b = d1 ^ d2 ^ d3;
          endcase
        end
        3'd3: begin
          unique case (pos)
            3'd0:    b = d0 ^ d1 ^ d3;
            3'd1:    b = d0 ^ d1 ^ d2;
            default: b = d1 ^ d2 ^ d3;
          endcase
        end
        3'd2: begin
          if (pos == 3'd0) b = d0 ^ d1 ^ d2;
          else b = d1 ^ d2 ^ d3;
        end
        default: b = d0 ^ d1 ^ d2 ^ d3;
      endcase
    end
    return b;
  endfunction

  // which of the 16 candidates carry a one at this position
  function automatic logic [15:0] code_mask(input logic [CODE_RATE_W-1:0] r,
                                            input logic [2:0] pos);
    logic [15:0] m;
    for (int i = 0; i < 16; i++) begin
      m[i] = code_bit(r, 4'(i), pos);
    end
    return m;
  endfunction

endpackage

>>> rtl/shd_if.sv
// Valid/ready channel interfaces for the decoder: soft input, decoded
// output and the code-rate write channel. No dependencies.
interface shd_in_if #(parameter int SOFT_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [SOFT_WIDTH-1:0] soft_value;
  modport source (output valid, output soft_value, input ready);
  modport sink   (input valid, input soft_value, output ready);
endinterface

interface shd_out_if;
  logic valid;
  logic ready;
  logic decoded_bit;
  logic last_bit;
  modport source (output valid, output decoded_bit, output last_bit, input ready);
  modport sink   (input valid, input decoded_bit, input last_bit, output ready);
endinterface

interface shd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] code_rate;
  modport source (output valid, output code_rate, input ready);
  modport sink   (input valid, input code_rate, output ready);
endinterface

>>> rtl/shd_cell.sv
// One decoder cell: four candidate score accumulators, a local argmin and
// one stage of the argmin token chain. Depends on shd_pkg.
module shd_cell #(
  parameter int         SOFT_WIDTH = shd_pkg::SOFT_WIDTH_DEF,
  parameter logic [1:0] CELL_IDX   = 2'd0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  shd_pkg::acc_ctl_t            acc_ctl,
  input  logic [3:0]                   code_bits,
  input  logic signed [SOFT_WIDTH-1:0] soft_value,
  input  shd_pkg::tok_t                tok_in,
  input  logic signed [SOFT_WIDTH+2:0] tok_in_score,
  output shd_pkg::tok_t                tok_out,
  output logic signed [SOFT_WIDTH+2:0] tok_out_score
);
  import shd_pkg::*;

  localparam int SCORE_W = SOFT_WIDTH + 3;

  logic signed [SCORE_W-1:0] acc_r [4];
  logic signed [SCORE_W-1:0] acc_nxt [4];
  logic signed [SCORE_W-1:0] v_ext;
  logic signed [SCORE_W-1:0] s01, s23, loc_score_nxt, loc_score_r;
  logic [1:0]                i01, i23, loc_idx_nxt, loc_idx_r;
  tok_t                      tok_r, tok_nxt;
  logic signed [SCORE_W-1:0] tok_score_r, tok_score_nxt;

  assign v_ext = SCORE_W'(soft_value);

  // accumulate; position zero restarts the sum
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc_nxt[j] = (acc_ctl.first ? '0 : acc_r[j]) + (code_bits[j] ? v_ext : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ctl.fire) begin
      for (int j = 0; j < 4; j++) acc_r[j] <= acc_nxt[j];
    end
  end

  // local argmin of four, lower index wins ties
  always_comb begin
    i01 = (acc_r[1] < acc_r[0]) ? 2'd1 : 2'd0;
    s01 = (acc_r[1] < acc_r[0]) ? acc_r[1] : acc_r[0];
    i23 = (acc_r[3] < acc_r[2]) ? 2'd3 : 2'd2;
    s23 = (acc_r[3] < acc_r[2]) ? acc_r[3] : acc_r[2];
    loc_idx_nxt   = (s23 < s01) ? i23 : i01;
    loc_score_nxt = (s23 < s01) ? s23 : s01;
  end

  always_ff @(posedge clk) begin
    if (acc_ctl.grp_end) begin
      loc_idx_r   <= loc_idx_nxt;
      loc_score_r <= loc_score_nxt;
    end
  end

  // token stage: replace only on strictly lower score
  always_comb begin
    tok_nxt       = tok_in;
    tok_score_nxt = tok_in_score;
    if (tok_in.vld && (loc_score_r < tok_in_score)) begin
      tok_nxt.idx   = {CELL_IDX, loc_idx_r};
      tok_score_nxt = loc_score_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.idx   <= tok_nxt.idx;
    tok_score_r <= tok_score_nxt;
  end

  assign tok_out       = tok_r;
  assign tok_out_score = tok_score_r;

endmodule

>>> rtl/shd_nib_out.sv
// Decoded nibble queue and bit serializer, MSB first with last marker.
// Depends on shd_pkg and shd_out_if.
module shd_nib_out (
  input  logic          clk,
  input  logic          rst_n,
  input  shd_pkg::tok_t nib_in,
  shd_out_if.source     out_chan
);
  import shd_pkg::*;

  logic [3:0]           mem_r [NIB_DEPTH];
  logic [NIB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NIB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]           bit_r, bit_nxt;
  logic [3:0]           head;
  logic                 out_fire, pop;

  assign head     = mem_r[rd_ptr_r];
  assign out_fire = out_chan.valid && out_chan.ready;
  assign pop      = out_fire && (bit_r == LAST_BIT_IDX);

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.decoded_bit = head[LAST_BIT_IDX - bit_r];
  assign out_chan.last_bit    = (bit_r == LAST_BIT_IDX);

  // pointers, fill count and bit counter
  always_comb begin
    wr_ptr_nxt = nib_in.vld ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + NIB_CNT_W'(nib_in.vld) - NIB_CNT_W'(pop);
    bit_nxt    = out_fire ? bit_r + 1'b1 : bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      bit_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      bit_r    <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (nib_in.vld) mem_r[wr_ptr_r] <= nib_in.idx;
  end

endmodule

>>> rtl/soft_hamming_ml_decoder_unit.sv
// Soft-decision ML decoder for the (4+r,4) Hamming-type code, top level.
// Depends on shd_pkg, shd_if, shd_cell and shd_nib_out.
// Throughput: one soft value per cycle, but a codeword's last value stalls
// while the queue holds a full set of pending codewords; each codeword of
// 5..8 values yields four one-bit results, the first offered after the local
// argmin stage, four chain cells and the queue write. Reset: synchronous,
// active low; code rate returns to 4, position to zero, queue and chain empty.
module soft_hamming_ml_decoder_unit #(
  parameter int SOFT_WIDTH = shd_pkg::SOFT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  shd_in_if.sink    in_chan,
  shd_out_if.source out_chan,
  shd_cfg_if.sink   cfg_chan
);
  import shd_pkg::*;

  localparam int SCORE_W = SOFT_WIDTH + 3;

  logic [CODE_RATE_W-1:0] code_rate_r, code_rate_nxt, rate_eff;
  logic [2:0]             pos_r, pos_nxt, last_pos;
  logic [NIB_CNT_W-1:0]   pend_r, pend_nxt;
  logic                   grp_end_r, loc_vld_r;
  logic                   is_last, in_fire, cfg_fire, grp_done;
  logic [15:0]            mask;
  acc_ctl_t               acc_ctl;

  tok_t                      tok [NUM_CELLS+1];
  logic signed [SCORE_W-1:0] tok_score [NUM_CELLS+1];

  // position tracking and flow control
  assign rate_eff = eff_rate(code_rate_r);
  assign last_pos = rate_eff + 3'd3;
  assign is_last  = (pos_r == last_pos);
  assign mask     = code_mask(rate_eff, pos_r);

  assign in_chan.ready  = !(is_last && (pend_r == NIB_CNT_W'(NIB_DEPTH)));
  assign cfg_chan.ready = 1'b1;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign grp_done = out_chan.valid && out_chan.ready && out_chan.last_bit;

  always_comb begin
    code_rate_nxt = cfg_fire ? cfg_chan.code_rate : code_rate_r;
    pos_nxt       = pos_r;
    if (cfg_fire) pos_nxt = '0;
    else if (in_fire) pos_nxt = is_last ? 3'd0 : pos_r + 3'd1;
    pend_nxt = pend_r + NIB_CNT_W'(in_fire && is_last) - NIB_CNT_W'(grp_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_rate_r <= RATE_RST;
      pos_r       <= '0;
      pend_r      <= '0;
      grp_end_r   <= 1'b0;
      loc_vld_r   <= 1'b0;
    end else begin
      code_rate_r <= code_rate_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      grp_end_r   <= in_fire && is_last;
      loc_vld_r   <= grp_end_r;
    end
  end

  assign acc_ctl.fire    = in_fire;
  assign acc_ctl.first   = (pos_r == '0);
  assign acc_ctl.grp_end = grp_end_r;

  // chain head: empty token with a score above any reachable sum
  assign tok[0].vld   = loc_vld_r;
  assign tok[0].idx   = '0;
  assign tok_score[0] = {1'b0, {(SCORE_W-1){1'b1}}};

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    shd_cell #(
      .SOFT_WIDTH (SOFT_WIDTH),
      .CELL_IDX   (2'(c))
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .acc_ctl       (acc_ctl),
      .code_bits     (mask[4*c +: 4]),
      .soft_value    (in_chan.soft_value),
      .tok_in        (tok[c]),
      .tok_in_score  (tok_score[c]),
      .tok_out       (tok[c+1]),
      .tok_out_score (tok_score[c+1])
    );
  end

  shd_nib_out u_nib_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .nib_in   (tok[NUM_CELLS]),
    .out_chan (out_chan)
  );

  // groups in flight never exceed the queue depth
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= NIB_CNT_W'(NIB_DEPTH))
    else $error("pending codeword count above queue depth");

  // every nibble leaving the chain traces back to a closed codeword
  a_chain_lat: assert property (@(posedge clk) disable iff (!rst_n)
    tok[NUM_CELLS].vld |-> $past(grp_end_r, 5))
    else $error("chain token without matching codeword end");

  // results are only offered while a codeword is outstanding
  a_out_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (pend_r != '0))
    else $error("output beat with no pending codeword");

  // closing a codeword without a retire bumps the pending count
  a_pend_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_last && !grp_done) |=> (pend_r == $past(pend_r) + 1'b1))
    else $error("pending count missed a closed codeword");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for soft_hamming_ml_decoder_unit: walks a directed table, then random
// codewords under three idle patterns, and checks every decoded beat against a local decoder.
// Depends on shd_pkg, the shd_*_if interfaces and the decoder RTL.
module testbench;
  import shd_pkg::*;

  localparam int SW             = SOFT_WIDTH_DEF;
  localparam int SETTLE_CYCLES  = 12;    // longer than the decode latency
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int ITEMS_PER_SEG  = 37;

  localparam logic signed [SW-1:0] SOFT_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SOFT_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum logic {ROW_SOFT, ROW_RATE} row_kind_t;
  typedef enum logic [1:0] {GRP_CODEWORD, GRP_NOISE, GRP_TIE} grp_style_t;

  typedef struct packed {
    row_kind_t            kind;
    logic signed [SW-1:0] value;    // soft value, or code rate on a rate row
    logic                 has_nib;  // nibble typed in on a codeword's last row
    logic [3:0]           nib;
  } dir_row_t;

  typedef struct packed {
    logic data_bit;
    logic last_flag;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;

  shd_in_if #(.SOFT_WIDTH(SW)) in_if ();
  shd_out_if                   out_if ();
  shd_cfg_if                   cfg_if ();

  soft_hamming_ml_decoder_unit #(.SOFT_WIDTH(SW)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // directed stimulus: reset rate, rate 0 tie, dropped partial word, rate 5 mixed word
  dir_row_t dir_tab [27] = '{
    '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0}, '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0},
    '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0}, '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0},
    '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0}, '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0},
    '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0}, '{ROW_SOFT, SOFT_MIN, 1'b1, 4'hF},
    '{ROW_RATE, 0, 1'b0, 4'h0},
    '{ROW_SOFT, 0, 1'b0, 4'h0}, '{ROW_SOFT, 0, 1'b0, 4'h0}, '{ROW_SOFT, 0, 1'b0, 4'h0},
    '{ROW_SOFT, 0, 1'b0, 4'h0}, '{ROW_SOFT, 0, 1'b1, 4'h0},
    '{ROW_RATE, 2, 1'b0, 4'h0},
    '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0}, '{ROW_SOFT, SOFT_MAX, 1'b0, 4'h0},
    '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0},
    '{ROW_RATE, 5, 1'b0, 4'h0},
    '{ROW_SOFT, 100, 1'b0, 4'h0}, '{ROW_SOFT, -200, 1'b0, 4'h0},
    '{ROW_SOFT, 300, 1'b0, 4'h0}, '{ROW_SOFT, -400, 1'b0, 4'h0},
    '{ROW_SOFT, SOFT_MAX, 1'b0, 4'h0}, '{ROW_SOFT, SOFT_MIN, 1'b0, 4'h0},
    '{ROW_SOFT, 5, 1'b0, 4'h0}, '{ROW_SOFT, -6, 1'b0, 4'h0}
  };

  // rate per random segment, four segments per idle pattern
  logic [CODE_RATE_W-1:0] seg_rates [12] = '{1, 2, 3, 4, 0, 6, 7, 3, 2, 1, 4, 5};

  // local decoder state
  logic signed [SW+2:0]   cand_score [16];
  logic [2:0]             word_pos;
  logic [CODE_RATE_W-1:0] rate_reg;

  beat_t bit_queue[$];
  int    fail_count = 0;
  int    quiet_cycles = 0;
  int    tx_idle_pct;
  int    rx_idle_pct;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // out-of-range rates fold onto 1 or 4
  function automatic logic [2:0] fold_rate(input logic [CODE_RATE_W-1:0] r);
    if (r == '0) return RATE_MIN;
    if (r > RATE_MAX) return RATE_MAX;
    return r;
  endfunction

  // bit at position pos of the codeword for nibble nib; nib[3] is the first data bit
  function automatic logic codeword_bit(input logic [2:0] r, input logic [3:0] nib,
                                        input logic [2:0] pos);
    logic [3:0] taps;
    if (pos >= r) return nib[3 - int'(pos - r)];
    // parity taps over {d0,d1,d2,d3}
    unique case (r)
      3'd4:    taps = (pos == 0) ? 4'b1101 : (pos == 1) ? 4'b1011 :
                      (pos == 2) ? 4'b1110 : 4'b0111;
      3'd3:    taps = (pos == 0) ? 4'b1101 : (pos == 1) ? 4'b1110 : 4'b0111;
      3'd2:    taps = (pos == 0) ? 4'b1110 : 4'b0111;
      default: taps = 4'b1111;
    endcase
    return ^(nib & taps);
  endfunction

  task automatic clear_word();
    for (int n = 0; n < 16; n++) cand_score[n] = '0;
    word_pos = '0;
  endtask

  // add one soft value to every candidate with a one here; pick the min at word end
  task automatic accumulate(input logic signed [SW-1:0] v, output bit word_done,
                            output logic [3:0] winner);
    logic [2:0] r;
    r         = fold_rate(rate_reg);
    word_done = 1'b0;
    winner    = 4'h0;
    for (int n = 0; n < 16; n++) begin
      if (codeword_bit(r, 4'(n), word_pos)) cand_score[n] = cand_score[n] + v;
    end
    if (word_pos + 1 < r + 4) begin
      word_pos = word_pos + 3'd1;
    end else begin
      // strict less-than keeps the lower index on ties
      for (int n = 1; n < 16; n++) begin
        if (cand_score[n] < cand_score[winner]) winner = 4'(n);
      end
      word_done = 1'b1;
      clear_word();
    end
  endtask

  // one input beat; the expected nibble comes from the decoder unless typed in
  task automatic send_soft(input logic signed [SW-1:0] v, input logic typed,
                           input logic [3:0] typed_nib);
    bit         done;
    logic [3:0] nib;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.soft_value = v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    accumulate(v, done, nib);
    if (done) begin
      if (typed) nib = typed_nib;
      for (int k = 0; k < 4; k++) begin
        bit_queue.push_back('{data_bit: nib[3-k], last_flag: (k == 3)});
      end
    end
  endtask

  // rate write only once the decoder has gone quiet; a partial word is dropped
  task automatic write_rate(input logic [CODE_RATE_W-1:0] r);
    @(negedge clk);
    in_if.valid = 1'b0;
    while (bit_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_if.valid     = 1'b1;
    cfg_if.code_rate = r;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    rate_reg = r;
    clear_word();
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // mostly noisy codewords; some full-range noise and some near-zero words for ties
  task automatic random_segment(input logic [CODE_RATE_W-1:0] r);
    grp_style_t           style;
    logic [3:0]           grp_nib;
    logic signed [SW-1:0] v;
    int                   pick;
    int                   mag;
    int                   noise;
    style   = GRP_CODEWORD;
    grp_nib = 4'h0;
    write_rate(r);
    for (int i = 0; i < ITEMS_PER_SEG; i++) begin
      if (word_pos == 0) begin
        pick    = $urandom_range(99);
        style   = (pick < 70) ? GRP_CODEWORD : (pick < 85) ? GRP_NOISE : GRP_TIE;
        grp_nib = 4'($urandom_range(15));
      end
      unique case (style)
        GRP_CODEWORD: begin
          mag   = $urandom_range(20000);
          noise = int'($urandom_range(24000)) - 12000;
          v     = SW'(codeword_bit(fold_rate(rate_reg), grp_nib, word_pos) ?
                      noise - mag : noise + mag);
        end
        GRP_NOISE: v = SW'($urandom);
        default:   v = SW'(int'($urandom_range(2)) - 1);
      endcase
      send_soft(v, 1'b0, 4'h0);
    end
  endtask

  task automatic log_mismatch(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  // result receiver stalls at random
  always @(negedge clk) out_if.ready = ($urandom_range(99) >= rx_idle_pct);

  // compare each decoded beat with the oldest expectation
  always @(posedge clk) begin : check_beats
    beat_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (bit_queue.size() == 0) begin
        log_mismatch("unexpected beat, decoded_bit", -1, int'(out_if.decoded_bit));
      end else begin
        want = bit_queue.pop_front();
        if (out_if.decoded_bit !== want.data_bit)
          log_mismatch("decoded_bit", int'(want.data_bit), int'(out_if.decoded_bit));
        if (out_if.last_bit !== want.last_flag)
          log_mismatch("last_bit", int'(want.last_flag), int'(out_if.last_bit));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.soft_value = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.code_rate = RATE_RST;
    tx_idle_pct      = 30;
    rx_idle_pct      = 85;
    rate_reg         = RATE_RST;
    clear_word();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_RATE) write_rate(dir_tab[i].value[CODE_RATE_W-1:0]);
      else send_soft(dir_tab[i].value, dir_tab[i].has_nib, dir_tab[i].nib);
    end

    // sender idles 30 / receiver 85, then swapped, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 85 : 0;
      rx_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 30 : 0;
      for (int s = 0; s < 4; s++) random_segment(seg_rates[ph*4 + s]);
    end

    @(negedge clk);
    in_if.valid = 1'b0;
    while (bit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && bit_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/shd_pkg.sv
rtl/shd_if.sv
rtl/shd_cell.sv
rtl/shd_nib_out.sv
rtl/soft_hamming_ml_decoder_unit.sv
sim/testbench.sv
